[hw/rtl/mplf_pkg.sv]
`timescale 1ns / 1ps

package mplf_pkg;

  // Widths fixed by the register map and the channel payloads.
  localparam int unsigned TEXT_W       = 8;
  localparam int unsigned LINE_INDEX_W = 16;
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned LEN_FIELD_W  = 4;
  localparam int unsigned COUNT_W      = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_AND_MODE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_COUNT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTHS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_0       = 3'd3;

  // Control handed to every cell of the byte window.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

[hw/rtl/mplf_cell.sv]
`timescale 1ns / 1ps

module mplf_cell import mplf_pkg::*; #(
  parameter int unsigned AGE           = 0,
  parameter int unsigned PATTERN_BYTES = 8,
  parameter int unsigned PATTERN_SLOTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cell_ctl_t                         ctl,
  input  logic [TEXT_W-1:0]                 win_byte,
  input  logic [PATTERN_BYTES*TEXT_W-1:0]   pattern [PATTERN_SLOTS],
  input  logic [$clog2(PATTERN_BYTES+1)-1:0] len    [PATTERN_SLOTS],
  output logic [PATTERN_SLOTS-1:0]          slot_eq,
  output logic [TEXT_W-1:0]                 byte_out
);

  localparam int unsigned LEN_W = $clog2(PATTERN_BYTES + 1);

  logic [TEXT_W-1:0] byte_r;

  // This cell sees the window byte of its age. For a pattern of length L it
  // compares against pattern byte L-1-AGE, and agrees trivially when the
  // pattern is too short to reach this far back.
  always_comb begin
    logic [LEN_W-1:0]  pos;
    logic [TEXT_W-1:0] pat_byte;
    for (int k = 0; k < PATTERN_SLOTS; k++) begin
      pos      = len[k] - LEN_W'(AGE + 1);
      pat_byte = '0;
      for (int j = 0; j < PATTERN_BYTES; j++) begin
        if (pos == LEN_W'(j)) begin
          pat_byte = pattern[k][j*TEXT_W +: TEXT_W];
        end
      end
      slot_eq[k] = (len[k] <= LEN_W'(AGE)) || (pat_byte == win_byte);
    end
  end

  // The byte moves one place older on each taken text byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (ctl.clear) begin
      byte_r <= '0;
    end else if (ctl.shift) begin
      byte_r <= win_byte;
    end
  end

  assign byte_out = byte_r;

endmodule

[hw/rtl/multi_pattern_line_filter_top.sv]
`timescale 1ns / 1ps

// Line filter over a byte stream with up to four fixed patterns.
// Input channel: in_text_byte with in_line_end and in_file_end marks, under
// in_valid / in_stall. A request is taken when in_valid is high and in_stall
// is low. One byte is taken per cycle; the pattern window is a row of cells,
// one per pattern byte, compared in the cycle the byte arrives.
// Result channel: out_found and out_line_index under out_valid / out_stall.
// A result appears in the cycle after the request that ends a line that
// matches (the first in its file) or that ends a file with no match.
// Throughput is one byte per cycle. in_stall is high only while a result
// sits in the output register and the receiver stalls it; the request that
// frees the register may be taken in the same cycle.
// Configuration: cfg_index / cfg_data under cfg_valid / cfg_ready; cfg_ready
// is always high, and registers should be written while the block is idle.
// Reset (rst_n low, synchronous) clears the configuration and line state, the
// window and the line count, and empties the output register (not its data).

module multi_pattern_line_filter_top import mplf_pkg::*; #(
  parameter int unsigned PATTERN_BYTES    = 8,
  parameter int unsigned PATTERN_SLOTS    = 4,
  parameter int unsigned LINE_NUMBER_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [TEXT_W-1:0]       in_text_byte,
  input  logic                    in_line_end,
  input  logic                    in_file_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic [LINE_INDEX_W-1:0] out_line_index,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned LEN_W   = $clog2(PATTERN_BYTES + 1);
  localparam int unsigned PAT_W   = PATTERN_BYTES * TEXT_W;
  localparam int unsigned LINE_W  = LINE_NUMBER_BITS;

  // Configuration registers.
  logic                        and_mode_r;
  logic [COUNT_W-1:0]          pattern_count_r;
  logic [PATTERN_SLOTS*LEN_FIELD_W-1:0] pattern_lengths_r;
  logic [PAT_W-1:0]            pattern_r [PATTERN_SLOTS];

  // Line and file state.
  logic [PATTERN_SLOTS-1:0]    hits_r, hits_nxt;
  logic [LEN_W-1:0]            bil_r, bil_nxt;
  logic                        zero_seen_r, zero_seen_nxt;
  logic [LINE_W-1:0]           line_cnt_r, line_cnt_nxt;
  logic                        file_matched_r, file_matched_nxt;

  // Output register.
  logic                        out_valid_r;
  logic                        out_found_r;
  logic [LINE_INDEX_W-1:0]     out_line_index_r;

  logic                        accept;
  logic                        take;
  logic                        line_done;
  logic [LEN_W-1:0]            len_w [PATTERN_SLOTS];
  logic [LEN_W-1:0]            cnt_now;
  logic [COUNT_W-1:0]          used_cnt;
  logic [PATTERN_SLOTS-1:0]    new_hit;
  logic [PATTERN_SLOTS-1:0]    hits_now;
  logic                        line_match;
  logic [LINE_W-1:0]           cnt_inc;
  logic [LINE_INDEX_W-1:0]     cnt_index;
  logic                        res_valid;
  logic                        res_found;
  cell_ctl_t                   ctl;
  logic [TEXT_W-1:0]           chain_w [PATTERN_BYTES+1];
  logic [PATTERN_SLOTS-1:0]    eq_w    [PATTERN_BYTES];

  assign cfg_ready = 1'b1;

  // Register writes; pattern writes to slots that are not built are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      and_mode_r        <= 1'b0;
      pattern_count_r   <= '0;
      pattern_lengths_r <= '0;
      for (int k = 0; k < PATTERN_SLOTS; k++) begin
        pattern_r[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AND_MODE:        and_mode_r        <= cfg_data[0];
        CFG_PATTERN_COUNT:   pattern_count_r   <= cfg_data[COUNT_W-1:0];
        CFG_PATTERN_LENGTHS: pattern_lengths_r <= cfg_data[PATTERN_SLOTS*LEN_FIELD_W-1:0];
        default: begin
          for (int k = 0; k < PATTERN_SLOTS; k++) begin
            if (cfg_index == CFG_PATTERN_0 + CFG_INDEX_W'(k)) begin
              pattern_r[k] <= cfg_data[PAT_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // Lengths above the window size act as the window size.
  always_comb begin
    logic [LEN_FIELD_W-1:0] raw;
    for (int k = 0; k < PATTERN_SLOTS; k++) begin
      raw      = pattern_lengths_r[k*LEN_FIELD_W +: LEN_FIELD_W];
      len_w[k] = (raw > LEN_FIELD_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES)
                                                     : LEN_W'(raw);
    end
  end

  assign used_cnt = (pattern_count_r > COUNT_W'(PATTERN_SLOTS)) ?
                    COUNT_W'(PATTERN_SLOTS) : pattern_count_r;

  // Request handshake: stall only while a finished result is held back.
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign line_done = in_line_end || in_file_end;
  assign take      = !zero_seen_r && (in_text_byte != '0);

  assign ctl.shift = accept && !file_matched_r && take;
  assign ctl.clear = accept && line_done;

  // Row of window cells; the newest byte enters at cell zero.
  assign chain_w[0] = in_text_byte;

  for (genvar a = 0; a < PATTERN_BYTES; a++) begin : g_cell
    mplf_cell #(
      .AGE           (a),
      .PATTERN_BYTES (PATTERN_BYTES),
      .PATTERN_SLOTS (PATTERN_SLOTS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .win_byte (chain_w[a]),
      .pattern  (pattern_r),
      .len      (len_w),
      .slot_eq  (eq_w[a]),
      .byte_out (chain_w[a+1])
    );
  end

  // Window fill including the byte now arriving.
  assign cnt_now = (bil_r == LEN_W'(PATTERN_BYTES)) ? bil_r : bil_r + LEN_W'(1);

  // A slot hits when every cell agrees and the window holds enough bytes.
  always_comb begin
    logic all_eq;
    for (int k = 0; k < PATTERN_SLOTS; k++) begin
      all_eq = 1'b1;
      for (int a = 0; a < PATTERN_BYTES; a++) begin
        all_eq = all_eq && eq_w[a][k];
      end
      new_hit[k] = take && (len_w[k] != '0) && (len_w[k] <= cnt_now) && all_eq;
    end
  end

  assign hits_now = hits_r | new_hit;

  // Line decision over the slots in use; an empty pattern always counts.
  always_comb begin
    logic all_hit;
    logic any_hit;
    all_hit = 1'b1;
    any_hit = 1'b0;
    for (int k = 0; k < PATTERN_SLOTS; k++) begin
      if (COUNT_W'(k) < used_cnt) begin
        if ((len_w[k] == '0) || hits_now[k]) begin
          any_hit = 1'b1;
        end else begin
          all_hit = 1'b0;
        end
      end
    end
    line_match = and_mode_r ? all_hit : any_hit;
  end

  // Saturating line number and its reported form.
  assign cnt_inc = (line_cnt_r != '1) ? line_cnt_r + LINE_W'(1) : line_cnt_r;

  if (LINE_W > LINE_INDEX_W) begin : g_idx_sat
    assign cnt_index = (cnt_inc > LINE_W'({LINE_INDEX_W{1'b1}})) ?
                       {LINE_INDEX_W{1'b1}} : cnt_inc[LINE_INDEX_W-1:0];
  end else begin : g_idx_ext
    assign cnt_index = LINE_INDEX_W'(cnt_inc);
  end

  assign res_found = line_done && line_match;
  assign res_valid = accept && !file_matched_r && (res_found || in_file_end);

  // Next line and file state.
  always_comb begin
    hits_nxt         = hits_r;
    bil_nxt          = bil_r;
    zero_seen_nxt    = zero_seen_r;
    line_cnt_nxt     = line_cnt_r;
    file_matched_nxt = file_matched_r;
    if (accept) begin
      if (!file_matched_r) begin
        if (take) begin
          hits_nxt = hits_now;
          bil_nxt  = cnt_now;
        end else if (!zero_seen_r) begin
          zero_seen_nxt = 1'b1;
        end
        if (line_done) begin
          line_cnt_nxt = cnt_inc;
          if (line_match) begin
            file_matched_nxt = 1'b1;
          end
        end
      end
      if (line_done) begin
        hits_nxt      = '0;
        bil_nxt       = '0;
        zero_seen_nxt = 1'b0;
      end
      if (in_file_end) begin
        line_cnt_nxt     = '0;
        file_matched_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r         <= '0;
      bil_r          <= '0;
      zero_seen_r    <= 1'b0;
      line_cnt_r     <= '0;
      file_matched_r <= 1'b0;
    end else begin
      hits_r         <= hits_nxt;
      bil_r          <= bil_nxt;
      zero_seen_r    <= zero_seen_nxt;
      line_cnt_r     <= line_cnt_nxt;
      file_matched_r <= file_matched_nxt;
    end
  end

  // Output register; reloads whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_found_r      <= res_found;
      out_line_index_r <= res_found ? cnt_index : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_line_index = out_line_index_r;

  // A reported "not found" carries line number zero.
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_line_index_r == '0)
    else $error("not-found result with non-zero line number");

  // A skipped file stays skipped until its file end.
  a_skip_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && file_matched_r && !in_file_end |=> file_matched_r)
    else $error("file skip released before file end");

  // Nothing is produced for bytes of a skipped file.
  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && file_matched_r |-> !res_valid)
    else $error("result produced inside a skipped file");

  // The window fill never passes the window size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bil_r <= LEN_W'(PATTERN_BYTES))
    else $error("window fill out of range");

  // A line clear reaches the oldest cell of the row.
  a_clear_tail: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> chain_w[PATTERN_BYTES] == '0 && hits_r == '0)
    else $error("line clear did not empty the window");

endmodule
